@@ design/tspc_pkg.sv @@
// ----------------------------------------------------------------------------
// tspc_pkg
// Shared types and constants of the tile and sprite pixel compositor.
// ----------------------------------------------------------------------------
package tspc_pkg;

  localparam logic [1:0] MODE_MEM_WRITE    = 2'd0;
  localparam logic [1:0] MODE_SPRITE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RENDER       = 2'd2;
  localparam logic [1:0] MODE_COUNT        = 2'd3;

  localparam logic [1:0] SRC_BACK   = 2'd0;
  localparam logic [1:0] SRC_ONE    = 2'd1;
  localparam logic [1:0] SRC_TWO    = 2'd2;
  localparam logic [1:0] SRC_SPRITE = 2'd3;

  localparam logic [2:0] CFG_DISPLAY_CONTROL  = 3'd0;
  localparam logic [2:0] CFG_BACK_COLOR_INDEX = 3'd1;
  localparam logic [2:0] CFG_SCROLL_ONE       = 3'd2;
  localparam logic [2:0] CFG_SCROLL_TWO       = 3'd3;
  localparam logic [2:0] CFG_MAP_BASES        = 3'd4;
  localparam logic [2:0] CFG_LAYER_TWO_WINDOW = 3'd5;
  localparam logic [2:0] CFG_SPRITE_WINDOW    = 3'd6;

  localparam logic [15:0] PALETTE_BASE = 16'hfe00;
  localparam logic [15:0] TILE_BASE    = 16'h4000;
  localparam logic [2:0]  FLIP_MASK    = 3'd7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [31:0] write_data;
    logic [7:0]  hclk;
    logic [7:0]  vclk;
  } item_t;

  typedef struct packed {
    logic [7:0]  display_control;
    logic [7:0]  back_color_index;
    logic [15:0] scroll_one;
    logic [15:0] scroll_two;
    logic [9:0]  map_bases;
    logic [31:0] layer_two_window;
    logic [15:0] sprite_window;
  } cfg_t;

endpackage

@@ design/tspc_front.sv @@
// ----------------------------------------------------------------------------
// tspc_front
// Accepts input items, drops sprite writes to absent slots and queues the rest.
// ----------------------------------------------------------------------------
module tspc_front #(
  parameter int SPRITE_SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tspc_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output tspc_pkg::item_t q_item
);

  localparam int CW = tspc_pkg::QUEUE_AW + 1;

  tspc_pkg::item_t             slots [tspc_pkg::QUEUE_DEPTH];
  logic [tspc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [tspc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [CW-1:0]                 count;
  logic                          keep;
  logic                          push;
  logic                          pop;

  // Sprite writes beyond the table are accepted and dropped here.
  assign keep = !((in_item.mode == tspc_pkg::MODE_SPRITE_WRITE) &&
                  (in_item.address >= 16'(SPRITE_SLOTS)));
  assign in_ready = (count != CW'(tspc_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ design/tspc_back.sv @@
// ----------------------------------------------------------------------------
// tspc_back
// Executes queued items: memory, sprite and count writes, and the render walk.
// ----------------------------------------------------------------------------
module tspc_back #(
  parameter int SPRITE_SLOTS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  tspc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_pop,
  input  tspc_pkg::item_t q_item,
  output logic            res_valid,
  input  logic            res_ready,
  output logic [1:0]      res_source,
  output logic [11:0]     res_color
);

  localparam int SLOT_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(SPRITE_SLOTS + 1);
  localparam int MEM_WORDS = 32768;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BACK   = 4'd1;
  localparam logic [3:0] ST_LMAP   = 4'd2;
  localparam logic [3:0] ST_LTILE  = 4'd3;
  localparam logic [3:0] ST_PIX0   = 4'd4;
  localparam logic [3:0] ST_PIX1   = 4'd5;
  localparam logic [3:0] ST_PIX2   = 4'd6;
  localparam logic [3:0] ST_PAL    = 4'd7;
  localparam logic [3:0] ST_PALD   = 4'd8;
  localparam logic [3:0] ST_SSTART = 4'd9;
  localparam logic [3:0] ST_SREAD  = 4'd10;
  localparam logic [3:0] ST_SEVAL  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  localparam logic [1:0] PH_ONE = 2'd0;
  localparam logic [1:0] PH_TWO = 2'd1;
  localparam logic [1:0] PH_SPR = 2'd2;

  logic [15:0]       vram [MEM_WORDS];
  logic [31:0]       sprites [SPRITE_SLOTS];
  logic [15:0]       rdata;
  logic [31:0]       spr_rdata;
  logic [14:0]       rd_addr;

  logic [3:0]        state;
  logic [1:0]        phase;
  logic [7:0]        h;
  logic [7:0]        v;
  logic [1:0]        src;
  logic [11:0]       color;
  logic [15:0]       base;
  logic [2:0]        ty;
  logic [2:0]        tx;
  logic [15:0]       word0;
  logic [3:0]        pix;
  logic [3:0]        pal;
  logic              prio;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  sprite_count;

  logic              fmt_packed;
  logic              fmt_planar;
  logic [15:0]       scroll;
  logic [4:0]        mbase;
  logic [7:0]        sy;
  logic [7:0]        sx;
  logic [15:0]       map_addr;
  logic              win_in;
  logic              layer_en;
  logic [15:0]       row;
  logic [15:0]       row2;
  logic [15:0]       pk_addr;
  logic [7:0]        pk_byte;
  logic [3:0]        pk_pix;
  logic [3:0]        pl_pix;
  logic [15:0]       pal_addr;
  logic [15:0]       back_addr;
  logic [CNT_W-1:0]  idx_inc;
  logic [3:0]        adv_state;
  logic [1:0]        adv_phase;
  logic [CNT_W-1:0]  adv_idx;
  logic [8:0]        spr_hi;
  logic              spr_skip;
  logic              swin_in;
  logic [1:0]        phase_src;
  logic              take;

  assign fmt_packed = cfg.display_control[6];
  assign fmt_planar = cfg.display_control[7];

  // Layer address generation.
  assign scroll   = (phase == PH_TWO) ? cfg.scroll_two : cfg.scroll_one;
  assign mbase    = (phase == PH_TWO) ? cfg.map_bases[9:5] : cfg.map_bases[4:0];
  assign sy       = v + scroll[15:8];
  assign sx       = h + scroll[7:0];
  assign map_addr = {mbase, 11'b0} + {5'b0, sy[7:3], 6'b0} + {10'b0, sx[7:3], 1'b0};

  assign win_in = ((v >= cfg.layer_two_window[15:8]) && (v <= cfg.layer_two_window[31:24]) &&
                   (h >= cfg.layer_two_window[7:0]) && (h <= cfg.layer_two_window[23:16]))
                  ^ cfg.display_control[5];
  assign layer_en = (phase == PH_ONE) ? cfg.display_control[0] :
                    (cfg.display_control[1] && !(cfg.display_control[3] && !win_in));

  // Tile row fetch and pixel extraction.
  assign row     = base + {11'b0, ty, 2'b0};
  assign row2    = row + 16'd2;
  assign pk_addr = row + {14'b0, tx[2:1]};
  assign pk_byte = pk_addr[0] ? rdata[15:8] : rdata[7:0];
  assign pk_pix  = tx[0] ? pk_byte[3:0] : pk_byte[7:4];
  assign pl_pix  = {rdata[4'd8 + {1'b0, ~tx}], rdata[{1'b0, ~tx}],
                    word0[4'd8 + {1'b0, ~tx}], word0[{1'b0, ~tx}]};

  assign pal_addr  = tspc_pkg::PALETTE_BASE + {7'b0, pal, 5'b0} + {11'b0, pix, 1'b0};
  assign back_addr = tspc_pkg::PALETTE_BASE + {7'b0, cfg.back_color_index, 1'b0};

  // Sprite test.
  assign spr_hi   = {1'b0, spr_rdata[7:0]} + 9'd7;
  assign swin_in  = (h >= cfg.sprite_window[7:0]) && (h <= cfg.sprite_window[15:8]);
  assign spr_skip = (cfg.display_control[4] && spr_rdata[31] && !swin_in) ||
                    (h < spr_rdata[7:0]) || ({1'b0, h} > spr_hi);

  assign idx_inc = idx + 1'b1;

  always_comb begin
    case (phase)
      PH_ONE:  phase_src = tspc_pkg::SRC_ONE;
      PH_TWO:  phase_src = tspc_pkg::SRC_TWO;
      default: phase_src = tspc_pkg::SRC_SPRITE;
    endcase
  end

  // Step past the current layer or sprite.
  always_comb begin
    adv_phase = phase;
    adv_idx   = idx;
    case (phase)
      PH_ONE: begin
        adv_state = ST_LMAP;
        adv_phase = PH_TWO;
      end
      PH_TWO: begin
        adv_state = ST_SSTART;
      end
      default: begin
        if (idx_inc < sprite_count) begin
          adv_state = ST_SREAD;
          adv_idx   = idx_inc;
        end else begin
          adv_state = ST_DONE;
        end
      end
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: rd_addr = back_addr[15:1];
      ST_LMAP: rd_addr = map_addr[15:1];
      ST_PIX0: rd_addr = fmt_packed ? pk_addr[15:1] : row[15:1];
      ST_PIX1: rd_addr = row2[15:1];
      ST_PAL:  rd_addr = pal_addr[15:1];
      default: rd_addr = '0;
    endcase
  end

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign take  = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (q_pop && (q_item.mode == tspc_pkg::MODE_MEM_WRITE)) begin
      vram[q_item.address[15:1]] <= q_item.write_data[15:0];
    end
    rdata <= vram[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_item.mode == tspc_pkg::MODE_SPRITE_WRITE)) begin
      sprites[q_item.address[SLOT_W-1:0]] <= q_item.write_data;
    end
    spr_rdata <= sprites[idx[SLOT_W-1:0]];
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        h <= q_item.hclk;
        v <= q_item.vclk;
      end
      ST_LTILE: begin
        base <= tspc_pkg::TILE_BASE + {1'b0, rdata[13], 14'b0} + {2'b0, rdata[8:0], 5'b0};
        ty   <= sy[2:0] ^ (rdata[15] ? tspc_pkg::FLIP_MASK : 3'd0);
        tx   <= sx[2:0] ^ (rdata[14] ? tspc_pkg::FLIP_MASK : 3'd0);
        pal  <= rdata[12:9];
        prio <= 1'b1;
      end
      ST_SEVAL: begin
        base <= tspc_pkg::TILE_BASE + {2'b0, spr_rdata[24:16], 5'b0};
        ty   <= (v[2:0] - spr_rdata[10:8]) ^ (spr_rdata[29] ? tspc_pkg::FLIP_MASK : 3'd0);
        tx   <= (h[2:0] - spr_rdata[2:0]) ^ (spr_rdata[28] ? tspc_pkg::FLIP_MASK : 3'd0);
        pal  <= {1'b0, spr_rdata[27:25]};
        prio <= spr_rdata[30];
      end
      ST_PIX0: begin
        pix <= '0;
      end
      ST_PIX1: begin
        pix   <= pk_pix;
        word0 <= rdata;
      end
      ST_PIX2: begin
        pix <= pl_pix;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_ONE;
      idx          <= '0;
      sprite_count <= '0;
      src          <= tspc_pkg::SRC_BACK;
      color        <= '0;
      res_valid    <= 1'b0;
      res_source   <= tspc_pkg::SRC_BACK;
      res_color    <= '0;
    end else begin
      // ST_DONE reloads the result register itself when it is taken.
      if (res_valid && res_ready && (state != ST_DONE)) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.mode == tspc_pkg::MODE_COUNT) begin
              sprite_count <= (q_item.write_data > 32'(SPRITE_SLOTS)) ?
                              CNT_W'(SPRITE_SLOTS) : q_item.write_data[CNT_W-1:0];
            end
            if (q_item.mode == tspc_pkg::MODE_RENDER) begin
              state <= ST_BACK;
            end
          end
        end
        ST_BACK: begin
          color <= rdata[11:0];
          src   <= tspc_pkg::SRC_BACK;
          phase <= PH_ONE;
          state <= ST_LMAP;
        end
        ST_LMAP: begin
          if (layer_en) state <= ST_LTILE;
          else begin
            state <= adv_state;
            phase <= adv_phase;
          end
        end
        ST_LTILE: state <= ST_PIX0;
        ST_PIX0: begin
          state <= (fmt_packed || fmt_planar) ? ST_PIX1 : ST_PAL;
        end
        ST_PIX1: state <= fmt_packed ? ST_PAL : ST_PIX2;
        ST_PIX2: state <= ST_PAL;
        ST_PAL: begin
          // Transparent, or a sprite without priority over layer two: go on.
          if ((pix == 4'd0) ||
              ((phase == PH_SPR) && !prio && (src == tspc_pkg::SRC_TWO))) begin
            state <= adv_state;
            phase <= adv_phase;
            idx   <= adv_idx;
          end else begin
            state <= ST_PALD;
          end
        end
        ST_PALD: begin
          color <= rdata[11:0];
          src   <= phase_src;
          if (phase == PH_SPR) state <= ST_DONE;
          else begin
            state <= adv_state;
            phase <= adv_phase;
          end
        end
        ST_SSTART: begin
          if (cfg.display_control[2] && (sprite_count != '0)) begin
            idx   <= '0;
            phase <= PH_SPR;
            state <= ST_SREAD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SREAD: state <= ST_SEVAL;
        ST_SEVAL: begin
          if (spr_skip) begin
            state <= adv_state;
            idx   <= adv_idx;
          end else begin
            state <= ST_PIX0;
          end
        end
        ST_DONE: begin
          if (take) begin
            res_valid  <= 1'b1;
            res_source <= src;
            res_color  <= color;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/tile_sprite_pixel_compositor_top.sv @@
// ----------------------------------------------------------------------------
// tile_sprite_pixel_compositor_top
// Two tile layers and a sprite line composited from a 64 KiB video memory.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream (s_*) carries one item per transfer: tuser holds the mode
//   (memory word write, sprite entry write, render pixel, set sprite count),
//   tdata holds address, write data and the pixel position.
//   Only render items give a transfer on the master stream (m_*): tuser holds
//   the winning source, tdata the 12-bit color.
//   The cfg channel writes the display registers; it is always ready and is
//   to be used only while the block is idle.
// Structure:
//   Items pass a four-entry queue into a sequencer that owns the single read
//   port of video memory. Write items are carried out as they leave the queue.
//   A render item walks the background, each enabled tile layer and then the
//   sprite slots in turn, through dependent memory reads in the sequencer.
// Reset and stall:
//   rst clears the registers, the sprite count, the queue and the result.
//   Video memory and the sprite table hold garbage until written.
//   A stalled result holds in the output register; the queue keeps taking
//   items until it fills, then s_tready drops.
// ----------------------------------------------------------------------------
module tile_sprite_pixel_compositor_top #(
  parameter int SPRITE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // address[15:0], write_data[47:16], hclk[55:48], vclk[63:56]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // color[11:0], zero fill[15:12]
  output logic [1:0]  m_tuser,   // source[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  tspc_pkg::cfg_t  cfg;
  tspc_pkg::item_t in_item;
  tspc_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;
  logic [11:0]     res_color;

  // Unpack the stream payload.
  assign in_item.mode       = s_tuser;
  assign in_item.address    = s_tdata[15:0];
  assign in_item.write_data = s_tdata[47:16];
  assign in_item.hclk       = s_tdata[55:48];
  assign in_item.vclk       = s_tdata[63:56];

  // Register file; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tspc_pkg::CFG_DISPLAY_CONTROL:  cfg.display_control  <= cfg_data[7:0];
        tspc_pkg::CFG_BACK_COLOR_INDEX: cfg.back_color_index <= cfg_data[7:0];
        tspc_pkg::CFG_SCROLL_ONE:       cfg.scroll_one       <= cfg_data[15:0];
        tspc_pkg::CFG_SCROLL_TWO:       cfg.scroll_two       <= cfg_data[15:0];
        tspc_pkg::CFG_MAP_BASES:        cfg.map_bases        <= cfg_data[9:0];
        tspc_pkg::CFG_LAYER_TWO_WINDOW: cfg.layer_two_window <= cfg_data;
        tspc_pkg::CFG_SPRITE_WINDOW:    cfg.sprite_window    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  tspc_front #(
    .SPRITE_SLOTS(SPRITE_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  tspc_back #(
    .SPRITE_SLOTS(SPRITE_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_source (m_tuser),
    .res_color  (res_color)
  );

  assign m_tdata = {4'b0, res_color};

endmodule
